// File: sv/qpsa_pkg.sv
// ----------------------------------------------------------------------------
// qpsa_pkg
// Types, constants and the step schedule for the quaternion product square
// accumulator.
// ----------------------------------------------------------------------------
package qpsa_pkg;

  // Component indices: real, i, j, k
  localparam logic [1:0] C_W = 2'd0;
  localparam logic [1:0] C_X = 2'd1;
  localparam logic [1:0] C_Y = 2'd2;
  localparam logic [1:0] C_Z = 2'd3;

  // Sixteen product terms and seven square terms
  localparam int NUM_STEPS = 23;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // Input word
  typedef struct packed {
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic               first;
    logic               last;
  } qpsa_in_t;

  // Result word
  typedef struct packed {
    logic signed [63:0] sum_w;
    logic signed [63:0] sum_x;
    logic signed [63:0] sum_y;
    logic signed [63:0] sum_z;
    logic               saturated;
  } qpsa_out_t;

  // Control for one multiply step, carried along with the product
  typedef struct packed {
    logic       sq;       // operands come from the rounded product c
    logic       self_sq;  // square of c[ib], else c_w * c[ib]
    logic [1:0] ia;       // index into a
    logic [1:0] ib;       // index into b or c
    logic       neg;      // subtract the term
    logic       start;    // first term of a sum
    logic       done;     // last term of a sum
    logic       dbl;      // term counts twice
    logic [1:0] dest;     // component written by the finished sum
  } step_t;

  function automatic step_t mk(input logic sq, input logic self_sq,
                               input logic [1:0] ia, input logic [1:0] ib,
                               input logic neg, input logic start,
                               input logic done, input logic dbl,
                               input logic [1:0] dest);
    step_t t;
    t = '{sq, self_sq, ia, ib, neg, start, done, dbl, dest};
    return t;
  endfunction

  // Schedule: Hamilton product, then the square of c
  function automatic step_t step_info(input logic [STEP_W-1:0] s);
    step_t t;
    t = '0;
    unique case (s)
      // c_w = aw*bw - ax*bx - ay*by - az*bz
      5'd0:  t = mk(1'b0, 1'b0, C_W, C_W, 1'b0, 1'b1, 1'b0, 1'b0, C_W);
      5'd1:  t = mk(1'b0, 1'b0, C_X, C_X, 1'b1, 1'b0, 1'b0, 1'b0, C_W);
      5'd2:  t = mk(1'b0, 1'b0, C_Y, C_Y, 1'b1, 1'b0, 1'b0, 1'b0, C_W);
      5'd3:  t = mk(1'b0, 1'b0, C_Z, C_Z, 1'b1, 1'b0, 1'b1, 1'b0, C_W);
      // c_x = aw*bx + ax*bw + ay*bz - az*by
      5'd4:  t = mk(1'b0, 1'b0, C_W, C_X, 1'b0, 1'b1, 1'b0, 1'b0, C_X);
      5'd5:  t = mk(1'b0, 1'b0, C_X, C_W, 1'b0, 1'b0, 1'b0, 1'b0, C_X);
      5'd6:  t = mk(1'b0, 1'b0, C_Y, C_Z, 1'b0, 1'b0, 1'b0, 1'b0, C_X);
      5'd7:  t = mk(1'b0, 1'b0, C_Z, C_Y, 1'b1, 1'b0, 1'b1, 1'b0, C_X);
      // c_y = aw*by - ax*bz + ay*bw + az*bx
      5'd8:  t = mk(1'b0, 1'b0, C_W, C_Y, 1'b0, 1'b1, 1'b0, 1'b0, C_Y);
      5'd9:  t = mk(1'b0, 1'b0, C_X, C_Z, 1'b1, 1'b0, 1'b0, 1'b0, C_Y);
      5'd10: t = mk(1'b0, 1'b0, C_Y, C_W, 1'b0, 1'b0, 1'b0, 1'b0, C_Y);
      5'd11: t = mk(1'b0, 1'b0, C_Z, C_X, 1'b0, 1'b0, 1'b1, 1'b0, C_Y);
      // c_z = aw*bz + ax*by - ay*bx + az*bw
      5'd12: t = mk(1'b0, 1'b0, C_W, C_Z, 1'b0, 1'b1, 1'b0, 1'b0, C_Z);
      5'd13: t = mk(1'b0, 1'b0, C_X, C_Y, 1'b0, 1'b0, 1'b0, 1'b0, C_Z);
      5'd14: t = mk(1'b0, 1'b0, C_Y, C_X, 1'b1, 1'b0, 1'b0, 1'b0, C_Z);
      5'd15: t = mk(1'b0, 1'b0, C_Z, C_W, 1'b0, 1'b0, 1'b1, 1'b0, C_Z);
      // real part of c squared
      5'd16: t = mk(1'b1, 1'b1, C_W, C_W, 1'b0, 1'b1, 1'b0, 1'b0, C_W);
      5'd17: t = mk(1'b1, 1'b1, C_W, C_X, 1'b1, 1'b0, 1'b0, 1'b0, C_W);
      5'd18: t = mk(1'b1, 1'b1, C_W, C_Y, 1'b1, 1'b0, 1'b0, 1'b0, C_W);
      5'd19: t = mk(1'b1, 1'b1, C_W, C_Z, 1'b1, 1'b0, 1'b1, 1'b0, C_W);
      // vector part of c squared: 2 c_w c_v
      5'd20: t = mk(1'b1, 1'b0, C_W, C_X, 1'b0, 1'b1, 1'b1, 1'b1, C_X);
      5'd21: t = mk(1'b1, 1'b0, C_W, C_Y, 1'b0, 1'b1, 1'b1, 1'b1, C_Y);
      5'd22: t = mk(1'b1, 1'b0, C_W, C_Z, 1'b0, 1'b1, 1'b1, 1'b1, C_Z);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: sv/quaternion_product_square_accumulate.sv
// ----------------------------------------------------------------------------
// quaternion_product_square_accumulate
// Hamilton product of two Q15.16 quaternions, rounded and saturated, whose
// square is added into a saturating Q47.16 quaternion accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one word holding
//   quaternions a and b plus the first and last flags. first clears the
//   accumulator and the saturation flag before the word is added; last
//   emits one result word after the add.
//   Result channel (out_valid / out_stall / out_data) carries the four sums
//   and the sticky saturation flag, held in an output register.
//   One signed 32x32 multiplier does all 23 multiplies of a word, one per
//   cycle, followed by an accumulate, a round and a saturating add stage.
//   A new word is taken only once the previous word has drained through
//   the pipeline; in_stall is high while a word is being worked on.
//   A pending result waiting under out_stall does not hold up the next
//   word; only when the next result is ready and the register is still
//   occupied does the block wait.
//   Reset clears the accumulator, the saturation flag and the output valid.
// ----------------------------------------------------------------------------
module quaternion_product_square_accumulate
  import qpsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  qpsa_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output qpsa_out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  logic                last_r;
  logic                ovf_r;
  logic                out_valid_r;
  qpsa_out_t           out_data_r;

  logic signed [31:0]  a_r [4];
  logic signed [31:0]  b_r [4];
  logic signed [31:0]  c_r [4];
  logic signed [63:0]  acc_r [4];

  logic                accept;
  logic                issue;
  step_t               st;
  logic signed [31:0]  opb_c;
  logic signed [31:0]  op_a;
  logic signed [31:0]  op_b;

  logic                prod_v;
  logic signed [63:0]  prod;
  step_t               ptag;

  logic signed [65:0]  wacc_r;
  logic signed [65:0]  wacc_nxt;
  logic signed [65:0]  addend;
  logic signed [65:0]  grp_r;
  step_t               gtag_r;
  logic                grp_v_r;

  logic signed [65:0]  rnd;
  logic signed [49:0]  shr;
  logic                ovf_pos;
  logic                ovf_neg;
  logic signed [31:0]  c_val;

  logic signed [63:0]  term_r;
  logic [1:0]          tdest_r;
  logic                term_v_r;

  logic signed [64:0]  ssum;
  logic signed [63:0]  sat_val;
  logic                sat_ovf;

  logic                idle_pipe;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign issue     = (state_r == S_RUN);

  // operand selection for the shared multiplier
  assign st    = step_info(step_r);
  assign opb_c = c_r[st.ib];
  assign op_a  = st.sq ? (st.self_sq ? opb_c : c_r[C_W]) : a_r[st.ia];
  assign op_b  = st.sq ? opb_c : b_r[st.ib];

  qpsa_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .op_a     (op_a),
    .op_b     (op_b),
    .tag      (st),
    .prod_v_r (prod_v),
    .prod_r   (prod),
    .tag_r    (ptag)
  );

  // accumulate stage: wide running sum of signed terms
  assign addend   = ptag.dbl ? {prod[63], prod, 1'b0} : {{2{prod[63]}}, prod};
  assign wacc_nxt = ptag.neg ? ((ptag.start ? 66'sd0 : wacc_r) - addend)
                             : ((ptag.start ? 66'sd0 : wacc_r) + addend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
    end else begin
      grp_v_r <= prod_v && ptag.done;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_v) begin
      wacc_r <= wacc_nxt;
      if (ptag.done) begin
        grp_r  <= wacc_nxt;
        gtag_r <= ptag;
      end
    end
  end

  // round stage: drop 16 fraction bits, ties upward; product sums saturate to 32 bits
  assign rnd     = grp_r + 66'sd32768;
  assign shr     = rnd[65:16];
  assign ovf_pos = !shr[49] && (|shr[48:31]);
  assign ovf_neg = shr[49] && !(&shr[48:31]);

  always_comb begin
    priority if (ovf_pos) begin
      c_val = 32'sh7FFF_FFFF;
    end else if (ovf_neg) begin
      c_val = 32'sh8000_0000;
    end else begin
      c_val = shr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_v_r <= 1'b0;
    end else begin
      term_v_r <= grp_v_r && gtag_r.sq;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_v_r) begin
      if (gtag_r.sq) begin
        term_r  <= {{14{shr[49]}}, shr};
        tdest_r <= gtag_r.dest;
      end else begin
        c_r[gtag_r.dest] <= c_val;
      end
    end
  end

  // saturating add into the accumulator
  assign ssum    = {acc_r[tdest_r][63], acc_r[tdest_r]} + {term_r[63], term_r};
  assign sat_ovf = (ssum[64] != ssum[63]);
  assign sat_val = sat_ovf ? (ssum[64] ? 64'sh8000_0000_0000_0000
                                       : 64'sh7FFF_FFFF_FFFF_FFFF)
                           : ssum[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= 64'sd0;
      end
    end else if (accept && in_data.first) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= 64'sd0;
      end
    end else if (term_v_r) begin
      acc_r[tdest_r] <= sat_val;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r[C_W] <= in_data.a_w;
      a_r[C_X] <= in_data.a_x;
      a_r[C_Y] <= in_data.a_y;
      a_r[C_Z] <= in_data.a_z;
      b_r[C_W] <= in_data.b_w;
      b_r[C_X] <= in_data.b_x;
      b_r[C_Y] <= in_data.b_y;
      b_r[C_Z] <= in_data.b_z;
    end
  end

  assign idle_pipe = !prod_v && !grp_v_r && !term_v_r;

  // sequencer, sticky flag and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      last_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // taken result drops unless a new one is loaded in the same cycle
      if (out_valid_r && !out_stall &&
          !((state_r == S_DRAIN) && idle_pipe && last_r)) begin
        out_valid_r <= 1'b0;
      end
      if ((grp_v_r && !gtag_r.sq && (ovf_pos || ovf_neg)) ||
          (term_v_r && sat_ovf)) begin
        ovf_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RUN;
            step_r  <= '0;
            last_r  <= in_data.last;
            if (in_data.first) begin
              ovf_r <= 1'b0;
            end
          end
        end
        S_RUN: begin
          if (step_r == LAST_STEP) begin
            state_r <= S_DRAIN;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (idle_pipe) begin
            if (!last_r) begin
              state_r <= S_IDLE;
            end else if (!out_valid_r || !out_stall) begin
              out_data_r.sum_w     <= acc_r[C_W];
              out_data_r.sum_x     <= acc_r[C_X];
              out_data_r.sum_y     <= acc_r[C_Y];
              out_data_r.sum_z     <= acc_r[C_Z];
              out_data_r.saturated <= ovf_r;
              out_valid_r          <= 1'b1;
              state_r              <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/qpsa_mul.sv
// ----------------------------------------------------------------------------
// qpsa_mul
// Shared signed 32x32 multiplier with registered product; the step control
// travels alongside so the accumulate stage knows what to do with it.
// ----------------------------------------------------------------------------
module qpsa_mul
  import qpsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               issue,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  input  step_t              tag,
  output logic               prod_v_r,
  output logic signed [63:0] prod_r,
  output step_t              tag_r
);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= issue;
    end
  end

  // product and control; operands sign-extended to the product width
  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= 64'(op_a) * 64'(op_b);
      tag_r  <= tag;
    end
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quaternion product square accumulator. Words
// go in through directed cases and random first/last sequences, including
// operands that saturate the rounded product. A scoreboard class predicts
// every emitted sum set and compares it field by field. Both channels idle
// at random in changing proportions.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qpsa_pkg::*;

  // Clamp bounds for rounded products and for the accumulator
  localparam logic signed [63:0] Q32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] Q32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q64_MIN = {1'b1, 63'd0};
  localparam logic signed [63:0] Q64_MAX = {1'b0, {63{1'b1}}};

  // Handy Q15.16 operands
  localparam logic signed [31:0] F_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] F_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] F_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] F_HALF = 32'sh0000_8000;
  localparam logic signed [31:0] F_LSB  = 32'sh0000_0001;

  localparam int RANDOM_WORDS = 1680;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400_000;

  // Magnitude classes for random operands
  typedef enum int {K_SMALL, K_MID, K_FULL, K_EDGE} span_e;

  // --------------------------------------------------------------------------
  // Scoreboard: running sums, sticky flag and the queue of sum sets due
  // --------------------------------------------------------------------------
  class sum_scoreboard;
    logic signed [63:0] acc [4];
    bit                 sat_seen;
    qpsa_out_t          expected_sums [$];
    int                 errors;
    int                 words_noted;
    int                 sums_checked;
    int                 sat_sums;

    function new();
      foreach (acc[i]) acc[i] = '0;
      sat_seen     = 1'b0;
      errors       = 0;
      words_noted  = 0;
      sums_checked = 0;
      sat_sums     = 0;
    endfunction

    // full-width signed product
    function logic signed [127:0] mul(input logic signed [63:0] p,
                                      input logic signed [63:0] q);
      logic signed [127:0] pw, qw;
      pw = p;
      qw = q;
      return pw * qw;
    endfunction

    // drop 16 fraction bits, half rounds up, clamp and note saturation
    function logic signed [63:0] round_clamp(input logic signed [127:0] v,
                                             input logic signed [127:0] lo,
                                             input logic signed [127:0] hi);
      logic signed [127:0] r;
      r = (v + 128'sd32768) >>> 16;
      if (r < lo) begin
        sat_seen = 1'b1;
        return lo[63:0];
      end
      if (r > hi) begin
        sat_seen = 1'b1;
        return hi[63:0];
      end
      return r[63:0];
    endfunction

    // accepted input word: update the sums, queue a sum set on last
    function void note_word(input qpsa_in_t w);
      logic signed [63:0]  aw, ax, ay, az, bw, bx, by, bz;
      logic signed [63:0]  cw, cx, cy, cz;
      logic signed [63:0]  term [4];
      logic signed [64:0]  s;
      logic signed [127:0] t;
      qpsa_out_t           e;
      aw = $signed(w.a_w);
      ax = $signed(w.a_x);
      ay = $signed(w.a_y);
      az = $signed(w.a_z);
      bw = $signed(w.b_w);
      bx = $signed(w.b_x);
      by = $signed(w.b_y);
      bz = $signed(w.b_z);
      words_noted++;
      if (w.first) begin
        foreach (acc[i]) acc[i] = '0;
        sat_seen = 1'b0;
      end

      // Hamilton product, rounded to Q15.16
      t  = mul(aw, bw) - mul(ax, bx) - mul(ay, by) - mul(az, bz);
      cw = round_clamp(t, Q32_MIN, Q32_MAX);
      t  = mul(aw, bx) + mul(ax, bw) + mul(ay, bz) - mul(az, by);
      cx = round_clamp(t, Q32_MIN, Q32_MAX);
      t  = mul(aw, by) - mul(ax, bz) + mul(ay, bw) + mul(az, bx);
      cy = round_clamp(t, Q32_MIN, Q32_MAX);
      t  = mul(aw, bz) + mul(ax, by) - mul(ay, bx) + mul(az, bw);
      cz = round_clamp(t, Q32_MIN, Q32_MAX);

      // c squared, rounded to Q47.16
      t       = mul(cw, cw) - mul(cx, cx) - mul(cy, cy) - mul(cz, cz);
      term[0] = round_clamp(t, Q64_MIN, Q64_MAX);
      t       = mul(cw, cx);
      term[1] = round_clamp(t + t, Q64_MIN, Q64_MAX);
      t       = mul(cw, cy);
      term[2] = round_clamp(t + t, Q64_MIN, Q64_MAX);
      t       = mul(cw, cz);
      term[3] = round_clamp(t + t, Q64_MIN, Q64_MAX);

      // saturating accumulate
      foreach (term[i]) begin
        s = acc[i] + term[i];
        if (s[64] != s[63]) begin
          sat_seen = 1'b1;
          acc[i]   = s[64] ? Q64_MIN : Q64_MAX;
        end else begin
          acc[i] = s[63:0];
        end
      end

      if (w.last) begin
        e.sum_w     = acc[0];
        e.sum_x     = acc[1];
        e.sum_y     = acc[2];
        e.sum_z     = acc[3];
        e.saturated = sat_seen;
        expected_sums.push_back(e);
      end
    endfunction

    function void report(input string field, input logic [63:0] want,
                         input logic [63:0] got);
      errors++;
      if (errors <= 10)
        $display("ERROR: sum set %0d %s: expected %h, got %h",
                 sums_checked, field, want, got);
    endfunction

    // accepted result word against the oldest sum set due
    function void check_result(input qpsa_out_t got);
      qpsa_out_t want;
      if (expected_sums.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result word with no sum set due: %h", got);
        return;
      end
      want = expected_sums.pop_front();
      sums_checked++;
      if (got.saturated === 1'b1) sat_sums++;
      if (got.sum_w !== want.sum_w) report("sum_w", want.sum_w, got.sum_w);
      if (got.sum_x !== want.sum_x) report("sum_x", want.sum_x, got.sum_x);
      if (got.sum_y !== want.sum_y) report("sum_y", want.sum_y, got.sum_y);
      if (got.sum_z !== want.sum_z) report("sum_z", want.sum_z, got.sum_z);
      if (got.saturated !== want.saturated)
        report("saturated", 64'(want.saturated), 64'(got.saturated));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  qpsa_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  qpsa_out_t out_data;

  int            sender_idle_pct = 18;
  int            stall_pct       = 77;
  sum_scoreboard sums;

  quaternion_product_square_accumulate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic qpsa_in_t make_word(
      input logic signed [31:0] aw, input logic signed [31:0] ax,
      input logic signed [31:0] ay, input logic signed [31:0] az,
      input logic signed [31:0] bw, input logic signed [31:0] bx,
      input logic signed [31:0] by, input logic signed [31:0] bz,
      input bit first, input bit last);
    return {aw, ax, ay, az, bw, bx, by, bz, first, last};
  endfunction

  function automatic logic signed [31:0] rand_comp(input span_e sp);
    logic signed [31:0] v;
    v = $urandom;
    case (sp)
      K_SMALL: v = v >>> 13;
      K_MID:   v = v >>> 7;
      K_FULL:  v = v;
      default: begin
        case ($urandom_range(0, 6))
          0:       v = F_MIN;
          1:       v = F_MAX;
          2:       v = '0;
          3:       v = F_ONE;
          4:       v = -F_ONE;
          5:       v = F_LSB;
          default: v = -F_LSB;
        endcase
      end
    endcase
    return v;
  endfunction

  // mostly small operands; some wide ones to provoke product saturation
  function automatic qpsa_in_t rand_word(input bit first, input bit last);
    logic [7:0][31:0] comp;
    span_e            sp;
    bit               mixed;
    int               r;
    r     = $urandom_range(0, 9);
    sp    = (r < 5) ? K_SMALL : (r < 7) ? K_MID : (r < 9) ? K_FULL : K_EDGE;
    mixed = ($urandom_range(0, 4) == 0);
    for (int i = 7; i >= 0; i--)
      comp[i] = rand_comp(mixed ? span_e'($urandom_range(0, 3)) : sp);
    return {comp, first, last};
  endfunction

  // --------------------------------------------------------------------------
  // Input side: optional idle cycles, then hold the word until taken
  // --------------------------------------------------------------------------
  task automatic send_word(input qpsa_in_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    sums.note_word(w);
  endtask

  task automatic send_directed();
    // from reset, no first: 1.0 * 2.0
    send_word(make_word(F_ONE, 0, 0, 0, 2 * F_ONE, 0, 0, 0, 1'b0, 1'b1));
    // zeros
    send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    // i * j = k, square is -1
    send_word(make_word(0, F_ONE, 0, 0, 0, 0, F_ONE, 0, 1'b1, 1'b1));
    // k * i = j, then a short sequence carried on without first
    send_word(make_word(0, 0, 0, F_ONE, 0, F_ONE, 0, 0, 1'b1, 1'b0));
    send_word(make_word(F_HALF, F_HALF, F_HALF, F_HALF,
                        F_HALF, -F_HALF, -F_HALF, -F_HALF, 1'b0, 1'b0));
    send_word(make_word(-3 * F_ONE - F_HALF, F_ONE, -F_HALF, 7 * F_ONE,
                        F_ONE + F_HALF, -2 * F_ONE, F_LSB, -F_LSB, 1'b0, 1'b1));
    // rounding ties: half up on the positive side, to zero on the negative
    send_word(make_word(F_LSB, 0, 0, 0, F_HALF, 0, 0, 0, 1'b1, 1'b1));
    send_word(make_word(-F_LSB, 0, 0, 0, F_HALF, 0, 0, 0, 1'b1, 1'b1));
    // tie in a doubled square term
    send_word(make_word(F_LSB, 32'sh4000, 0, 0, F_ONE, 0, 0, 0, 1'b1, 1'b1));
    // operand extremes, all saturating the product
    send_word(make_word(F_MAX, F_MAX, F_MAX, F_MAX,
                        F_MAX, F_MAX, F_MAX, F_MAX, 1'b1, 1'b1));
    send_word(make_word(F_MIN, F_MIN, F_MIN, F_MIN,
                        F_MIN, F_MIN, F_MIN, F_MIN, 1'b1, 1'b1));
    send_word(make_word(F_MAX, F_MAX, F_MAX, F_MAX,
                        F_MIN, F_MIN, F_MIN, F_MIN, 1'b1, 1'b1));
    send_word(make_word(F_MIN, F_MAX, F_MIN, F_MAX,
                        F_MAX, F_MIN, F_MAX, F_MIN, 1'b1, 1'b1));
    // flag stays set until the next first
    send_word(make_word(F_MAX, 0, 0, 0, F_MAX, 0, 0, 0, 1'b1, 1'b0));
    send_word(make_word(F_ONE, 0, 0, 0, F_ONE, 0, 0, 0, 1'b0, 1'b1));
    send_word(make_word(F_ONE, 0, 0, 0, F_ONE, 0, 0, 0, 1'b1, 1'b1));
    // first alone, then plain words, then last alone
    send_word(make_word(F_ONE, F_LSB, 0, 0, F_ONE, 0, F_LSB, 0, 1'b1, 1'b0));
    send_word(make_word(-F_ONE, 0, F_HALF, 0, F_ONE, F_HALF, 0, 0, 1'b0, 1'b0));
    send_word(make_word(F_MIN, 0, 0, 0, F_LSB, 0, 0, 0, 1'b0, 1'b0));
    send_word(make_word(0, F_MAX, 0, F_LSB, 0, F_LSB, 0, F_MIN, 1'b0, 1'b1));
  endtask

  // mostly well-formed first..last sequences, some words with random flags
  task automatic send_random(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_word(rand_word(i == 0, i == len - 1));
        sent += len;
      end else begin
        send_word(rand_word($urandom_range(0, 1), $urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, check each word taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sums.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: timed out after %0d cycles", CYCLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sums = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalling
    sender_idle_pct = 18;
    stall_pct       = 77;
    send_directed();
    send_random(RANDOM_WORDS / 3);

    // the other way round
    sender_idle_pct = 77;
    stall_pct       = 18;
    send_random(RANDOM_WORDS / 3);

    // flat out
    sender_idle_pct = 0;
    stall_pct       = 0;
    send_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
    in_valid <= 1'b0;

    while (sums.expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words: directed cases and random first/last sequences",
             sums.words_noted);
    $display("under three idle patterns; %0d sum sets checked, %0d flagged saturated.",
             sums.sums_checked, sums.sat_sums);
    if (sums.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches in total", sums.errors);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: quaternion_product_square_accumulate.f
sv/qpsa_pkg.sv
sv/qpsa_mul.sv
sv/quaternion_product_square_accumulate.sv
verif/testbench.sv
